>>> hw/rtl/ddo_pkg.sv
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared types, constants and the arctangent table of the differential-drive
// odometry block.
// ----------------------------------------------------------------------------
package ddo_pkg;

  // Datapath widths
  localparam int MUL_W      = 34;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 160;
  localparam int CFG_IDX_W  = 1;
  localparam int ANG_W      = 34;

  // Default CORDIC iteration count (valid range 12 to 32)
  localparam int CORDIC_STEPS_DEF = 24;

  // Register reset values
  localparam logic [31:0] GAIN_RESET = 32'd1756906;
  localparam logic [31:0] INV_RESET  = 32'd16777216;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GAIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INV  = 1'b1;

  // Request kinds
  localparam logic [1:0] KIND_LEFT   = 2'd0;
  localparam logic [1:0] KIND_RIGHT  = 2'd1;
  localparam logic [1:0] KIND_UPDATE = 2'd2;

  // Heading scale: round(2^31/pi/1e6 * 2^20)
  localparam logic [29:0] ANG_K       = 30'd716770142;
  // CORDIC start value, round(0.60725293500888 * 2^30)
  localparam logic [29:0] CORDIC_INIT = 30'd652032874;
  // Position divide by 256e6 = 2^11 * 125000; half-divisor added first
  localparam logic [26:0] POS_HALF    = 27'd128000000;
  localparam logic [16:0] DIV_LO      = 17'd125000;
  // floor(2^44 / 125000)
  localparam logic [27:0] RECIP_LO    = 28'd140737488;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_SPD,
    S_SPD_FIN,
    S_W,
    S_W_FIN,
    S_P,
    S_PL,
    S_PH,
    S_ANG,
    S_HD,
    S_CST,
    S_CWT,
    S_XM,
    S_XC,
    S_XD,
    S_XN,
    S_XR1,
    S_XR2,
    S_XQ,
    S_XQD,
    S_XCOR,
    S_XAPP,
    S_OUT
  } ddo_state_t;

  // CORDIC result, Q30
  typedef struct packed {
    logic signed [ANG_W-1:0] cosine;
    logic signed [ANG_W-1:0] sine;
  } ddo_trig_t;

  // atan(2^-i) as a binary angle, full circle = 2^32
  function automatic logic [29:0] atan_entry(input logic [4:0] idx);
    logic [29:0] v;
    unique case (idx)
      5'd0:  v = 30'd536870912;
      5'd1:  v = 30'd316933406;
      5'd2:  v = 30'd167458907;
      5'd3:  v = 30'd85004756;
      5'd4:  v = 30'd42667331;
      5'd5:  v = 30'd21354465;
      5'd6:  v = 30'd10679838;
      5'd7:  v = 30'd5340245;
      5'd8:  v = 30'd2670163;
      5'd9:  v = 30'd1335087;
      5'd10: v = 30'd667544;
      5'd11: v = 30'd333772;
      5'd12: v = 30'd166886;
      5'd13: v = 30'd83443;
      5'd14: v = 30'd41722;
      5'd15: v = 30'd20861;
      5'd16: v = 30'd10430;
      5'd17: v = 30'd5215;
      5'd18: v = 30'd2608;
      5'd19: v = 30'd1304;
      5'd20: v = 30'd652;
      5'd21: v = 30'd326;
      5'd22: v = 30'd163;
      5'd23: v = 30'd81;
      5'd24: v = 30'd41;
      5'd25: v = 30'd20;
      5'd26: v = 30'd10;
      5'd27: v = 30'd5;
      5'd28: v = 30'd3;
      5'd29: v = 30'd1;
      5'd30: v = 30'd1;
      5'd31: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

>>> hw/rtl/diff_drive_odometry.sv
// ----------------------------------------------------------------------------
// diff_drive_odometry
// Dead-reckoning odometry for a two-wheel differential-drive robot: wheel
// speeds from RPM samples, pose update with CORDIC heading projection.
// ----------------------------------------------------------------------------
//  channel  dir  handshake          payload
//  cfg_     in   cfg_valid/ready    cfg_index, cfg_data (register write)
//  in_      in   in_tvalid/tready   in_tuser = kind, in_tdata = rpm, time
//  out_     out  out_tvalid/tready  out_tdata = x, y, heading, v, yaw rate
//
//  An update request is paced by the chain of products through the
//  one shared multiplier and the one-step-per-cycle CORDIC. in_tready is
//  high only while the sequencer is idle, so no new request is taken until
//  the last one is through.
//  A finished result waits in the output register; a stalled out_tready
//  holds the sequencer only when the next result is ready to be loaded.
//  Reset (synchronous, active low) clears pose and wheel speeds and loads
//  the register defaults. cfg_ready is always high.
// ----------------------------------------------------------------------------
module diff_drive_odometry #(
  parameter int CORDIC_STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [ddo_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [31:0]                       cfg_data,
  // requests
  input  logic                              in_tvalid,
  output logic                              in_tready,
  // [23:0] wheel_rpm, [43:24] elapsed_time, [47:44] zero
  input  logic [ddo_pkg::IN_DATA_W-1:0]     in_tdata,
  // [1:0] kind
  input  logic [1:0]                        in_tuser,
  // results
  output logic                              out_tvalid,
  input  logic                              out_tready,
  // [31:0] pos_x, [63:32] pos_y, [95:64] heading,
  // [127:96] linear_speed, [159:128] yaw_rate
  output logic [ddo_pkg::OUT_DATA_W-1:0]    out_tdata
);

  localparam int MW = ddo_pkg::MUL_W;
  localparam int PW = ddo_pkg::PROD_W;

  // round-to-magnitude result into signed 32 bits with saturation
  function automatic logic [31:0] sat_rnd(input logic [47:0] m, input logic neg);
    logic [31:0] r;
    if (neg) begin
      r = (m > 48'h0000_8000_0000) ? 32'h8000_0000 : (32'd0 - m[31:0]);
    end else begin
      r = (m > 48'h0000_7FFF_FFFF) ? 32'h7FFF_FFFF : m[31:0];
    end
    return r;
  endfunction

  ddo_pkg::ddo_state_t state_r, state_nxt;

  // configuration and state
  logic [31:0]        gain_r;
  logic [31:0]        inv_r;
  logic [31:0]        vl_r;
  logic [31:0]        vr_r;
  logic [31:0]        px_r;
  logic [31:0]        py_r;
  logic [31:0]        hd_r;

  // working registers
  logic               side_r;
  logic [23:0]        rpm_mag_r;
  logic               rpm_neg_r;
  logic [19:0]        dt_r;
  logic [31:0]        v_r;
  logic [32:0]        d_r;
  logic [31:0]        vmag_r;
  logic [31:0]        w_r;
  logic [26:0]        ph_r;
  logic [30:0]        t_r;
  logic [31:0]        ang_r;
  ddo_pkg::ddo_trig_t trig_r;
  logic               axis_r;
  logic [MW-1:0]      cmag_r;
  logic               cneg_r;
  logic [43:0]        n_r;
  logic [49:0]        lo_r;
  logic [27:0]        q_r;

  // output register
  logic               out_valid_r;
  logic [31:0]        out_x_r;
  logic [31:0]        out_y_r;
  logic [31:0]        out_hd_r;
  logic [31:0]        out_v_r;
  logic [31:0]        out_w_r;

  // shared multiplier and CORDIC
  logic [MW-1:0]      mul_a;
  logic [MW-1:0]      mul_b;
  logic [PW-1:0]      prod;
  logic               cord_start;
  logic               cord_done;
  ddo_pkg::ddo_trig_t cord_trig;

  logic               in_req;
  logic               out_load;
  logic [32:0]        vsum;
  logic [32:0]        dsub;
  logic [31:0]        dmag;
  logic [31:0]        wmag;
  logic [MW-1:0]      trig_sel;
  logic [MW-1:0]      tmag;
  logic [56:0]        spd_sum;
  logic [64:0]        w_sum;
  logic [54:0]        t_sum;
  logic [57:0]        a_sum;
  logic [66:0]        c_sum;
  logic [54:0]        n_sum;
  logic [71:0]        q_sum;
  logic [44:0]        rem;

  ddo_mul u_mul (
    .clk  (clk),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  ddo_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cord_start),
    .angle (hd_r),
    .done  (cord_done),
    .trig  (cord_trig)
  );

  assign in_req   = in_tvalid && in_tready;
  assign out_load = (state_r == ddo_pkg::S_OUT) && (!out_valid_r || out_tready);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ddo_pkg::S_IDLE: begin
        if (in_tvalid) begin
          case (in_tuser)
            ddo_pkg::KIND_LEFT, ddo_pkg::KIND_RIGHT: state_nxt = ddo_pkg::S_SPD;
            ddo_pkg::KIND_UPDATE:                    state_nxt = ddo_pkg::S_W;
            default:                                 state_nxt = ddo_pkg::S_IDLE;
          endcase
        end
      end
      ddo_pkg::S_SPD:     state_nxt = ddo_pkg::S_SPD_FIN;
      ddo_pkg::S_SPD_FIN: state_nxt = ddo_pkg::S_IDLE;
      ddo_pkg::S_W:       state_nxt = ddo_pkg::S_W_FIN;
      ddo_pkg::S_W_FIN:   state_nxt = ddo_pkg::S_P;
      ddo_pkg::S_P:       state_nxt = ddo_pkg::S_PL;
      ddo_pkg::S_PL:      state_nxt = ddo_pkg::S_PH;
      ddo_pkg::S_PH:      state_nxt = ddo_pkg::S_ANG;
      ddo_pkg::S_ANG:     state_nxt = ddo_pkg::S_HD;
      ddo_pkg::S_HD:      state_nxt = ddo_pkg::S_CST;
      ddo_pkg::S_CST:     state_nxt = ddo_pkg::S_CWT;
      ddo_pkg::S_CWT: begin
        if (cord_done) state_nxt = ddo_pkg::S_XM;
      end
      ddo_pkg::S_XM:      state_nxt = ddo_pkg::S_XC;
      ddo_pkg::S_XC:      state_nxt = ddo_pkg::S_XD;
      ddo_pkg::S_XD:      state_nxt = ddo_pkg::S_XN;
      ddo_pkg::S_XN:      state_nxt = ddo_pkg::S_XR1;
      ddo_pkg::S_XR1:     state_nxt = ddo_pkg::S_XR2;
      ddo_pkg::S_XR2:     state_nxt = ddo_pkg::S_XQ;
      ddo_pkg::S_XQ:      state_nxt = ddo_pkg::S_XQD;
      ddo_pkg::S_XQD:     state_nxt = ddo_pkg::S_XCOR;
      ddo_pkg::S_XCOR:    state_nxt = ddo_pkg::S_XAPP;
      ddo_pkg::S_XAPP:    state_nxt = axis_r ? ddo_pkg::S_OUT : ddo_pkg::S_XM;
      ddo_pkg::S_OUT: begin
        if (!out_valid_r || out_tready) state_nxt = ddo_pkg::S_IDLE;
      end
      default:            state_nxt = ddo_pkg::S_IDLE;
    endcase
  end

  // operand magnitudes
  always_comb begin
    dmag     = d_r[32] ? 32'(-d_r) : d_r[31:0];
    wmag     = w_r[31] ? (32'd0 - w_r) : w_r;
    trig_sel = axis_r ? trig_r.sine : trig_r.cosine;
    tmag     = trig_sel[MW-1] ? (MW'(0) - trig_sel) : trig_sel;
  end

  // sequencer outputs: handshake, CORDIC start, multiplier operands
  always_comb begin
    in_tready  = (state_r == ddo_pkg::S_IDLE);
    cord_start = (state_r == ddo_pkg::S_CST);
    mul_a      = '0;
    mul_b      = '0;
    unique case (state_r)
      ddo_pkg::S_SPD: begin
        mul_a = MW'(rpm_mag_r);
        mul_b = MW'(gain_r);
      end
      ddo_pkg::S_W: begin
        mul_a = MW'(dmag);
        mul_b = MW'(inv_r);
      end
      ddo_pkg::S_P: begin
        mul_a = MW'(wmag);
        mul_b = MW'(dt_r);
      end
      ddo_pkg::S_PL: begin
        mul_a = MW'(prod[23:0]);
        mul_b = MW'(ddo_pkg::ANG_K);
      end
      ddo_pkg::S_PH: begin
        mul_a = MW'(ph_r);
        mul_b = MW'(ddo_pkg::ANG_K);
      end
      ddo_pkg::S_XM: begin
        mul_a = MW'(vmag_r);
        mul_b = tmag;
      end
      ddo_pkg::S_XD: begin
        mul_a = cmag_r;
        mul_b = MW'(dt_r);
      end
      ddo_pkg::S_XR1: begin
        mul_a = MW'(n_r[21:0]);
        mul_b = MW'(ddo_pkg::RECIP_LO);
      end
      ddo_pkg::S_XR2: begin
        mul_a = MW'(n_r[43:22]);
        mul_b = MW'(ddo_pkg::RECIP_LO);
      end
      ddo_pkg::S_XQD: begin
        mul_a = MW'(q_r);
        mul_b = MW'(ddo_pkg::DIV_LO);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // wheel sum and difference; rounding and scaling of the registered product
  always_comb begin
    vsum    = {vr_r[31], vr_r} + {vl_r[31], vl_r};
    dsub    = {vr_r[31], vr_r} - {vl_r[31], vl_r};
    spd_sum = {1'b0, prod[55:0]} + 57'd128;
    w_sum   = {1'b0, prod[63:0]} + 65'h80_0000;
    t_sum   = prod[54:0] + (55'd1 <<< 43);
    a_sum   = prod[57:0] + 58'(t_r);
    c_sum   = prod[66:0] + (67'd1 <<< 29);
    n_sum   = prod[54:0] + 55'(ddo_pkg::POS_HALF);
    q_sum   = {prod[49:0], 22'd0} + 72'(lo_r);
    rem     = {1'b0, n_r} - prod[44:0];
  end

  // state, configuration and control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ddo_pkg::S_IDLE;
      gain_r      <= ddo_pkg::GAIN_RESET;
      inv_r       <= ddo_pkg::INV_RESET;
      vl_r        <= '0;
      vr_r        <= '0;
      px_r        <= '0;
      py_r        <= '0;
      hd_r        <= '0;
      axis_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // register writes
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ddo_pkg::REG_GAIN: gain_r <= cfg_data;
          ddo_pkg::REG_INV:  inv_r  <= cfg_data;
          default:           gain_r <= gain_r;
        endcase
      end

      // wheel speed store
      if (state_r == ddo_pkg::S_SPD_FIN) begin
        if (side_r) begin
          vr_r <= sat_rnd(spd_sum[55:8], rpm_neg_r);
        end else begin
          vl_r <= sat_rnd(spd_sum[55:8], rpm_neg_r);
        end
      end

      // heading step
      if (state_r == ddo_pkg::S_HD) begin
        hd_r <= w_r[31] ? (hd_r - ang_r) : (hd_r + ang_r);
      end

      // position step, x then y
      if (state_r == ddo_pkg::S_W) begin
        axis_r <= 1'b0;
      end else if (state_r == ddo_pkg::S_XAPP) begin
        axis_r <= 1'b1;
        if (axis_r) begin
          py_r <= cneg_r ? (py_r - 32'(q_r)) : (py_r + 32'(q_r));
        end else begin
          px_r <= cneg_r ? (px_r - 32'(q_r)) : (px_r + 32'(q_r));
        end
      end

      // output register
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    if (in_req) begin
      side_r    <= (in_tuser == ddo_pkg::KIND_RIGHT);
      rpm_neg_r <= in_tdata[23];
      rpm_mag_r <= in_tdata[23] ? (24'd0 - in_tdata[23:0]) : in_tdata[23:0];
      dt_r      <= in_tdata[43:24];
      v_r       <= vsum[32:1];
      d_r       <= dsub;
    end
    unique case (state_r)
      ddo_pkg::S_W: begin
        vmag_r <= v_r[31] ? (32'd0 - v_r) : v_r;
      end
      ddo_pkg::S_W_FIN: begin
        w_r <= sat_rnd(48'(w_sum[64:24]), d_r[32]);
      end
      ddo_pkg::S_PL: begin
        ph_r <= prod[50:24];
      end
      ddo_pkg::S_PH: begin
        t_r <= t_sum[54:24];
      end
      ddo_pkg::S_ANG: begin
        ang_r <= a_sum[51:20];
      end
      ddo_pkg::S_CWT: begin
        if (cord_done) trig_r <= cord_trig;
      end
      ddo_pkg::S_XC: begin
        cmag_r <= c_sum[63:30];
        cneg_r <= v_r[31] ^ trig_sel[MW-1];
      end
      ddo_pkg::S_XN: begin
        n_r <= n_sum[54:11];
      end
      ddo_pkg::S_XR2: begin
        lo_r <= prod[49:0];
      end
      ddo_pkg::S_XQ: begin
        q_r <= q_sum[71:44];
      end
      ddo_pkg::S_XCOR: begin
        if (rem >= 45'(ddo_pkg::DIV_LO)) q_r <= q_r + 28'd1;
      end
      default: begin
        q_r <= q_r;
      end
    endcase
    if (out_load) begin
      out_x_r  <= px_r;
      out_y_r  <= py_r;
      out_hd_r <= hd_r;
      out_v_r  <= v_r;
      out_w_r  <= w_r;
    end
  end

  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_w_r, out_v_r, out_hd_r, out_y_r, out_x_r};

`ifndef SYNTH
  // an RPM request keeps the block busy on the next cycle
  a_spd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_req && (in_tuser == ddo_pkg::KIND_LEFT || in_tuser == ddo_pkg::KIND_RIGHT))
      |=> !in_tready)
    else $error("RPM request did not start the speed sequence");

  // a result is only raised from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ddo_pkg::S_OUT))
    else $error("result raised outside the output state");

  // the heading moves only in its update step
  a_hd_step: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(hd_r)) |-> $past(state_r == ddo_pkg::S_HD))
    else $error("heading changed outside its update step");

  // CORDIC completion is only seen while the sequencer waits for it
  a_cord_wait: assert property (@(posedge clk) disable iff (!rst_n)
    cord_done |-> (state_r == ddo_pkg::S_CWT))
    else $error("CORDIC finished while not awaited");
`endif

endmodule

>>> hw/rtl/ddo_mul.sv
// ----------------------------------------------------------------------------
// ddo_mul
// Shared unsigned multiplier with a registered product.
// ----------------------------------------------------------------------------
module ddo_mul (
  input  logic                        clk,
  input  logic [ddo_pkg::MUL_W-1:0]   a,
  input  logic [ddo_pkg::MUL_W-1:0]   b,
  output logic [ddo_pkg::PROD_W-1:0]  prod
);

  logic [ddo_pkg::PROD_W-1:0] prod_r;

  // product register
  always_ff @(posedge clk) begin
    prod_r <= a * b;
  end

  assign prod = prod_r;

endmodule

>>> hw/rtl/ddo_cordic.sv
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC: cos and sin in Q30 of a binary angle, one
// micro-rotation per cycle through a single add/shift stage.
// ----------------------------------------------------------------------------
module ddo_cordic #(
  parameter int STEPS = ddo_pkg::CORDIC_STEPS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [31:0]         angle,
  output logic                done,
  output ddo_pkg::ddo_trig_t  trig
);

  localparam int W = ddo_pkg::ANG_W;

  logic                run_r;
  logic                done_r;
  logic                flip_r;
  logic [4:0]          idx_r;
  logic signed [W-1:0] x_r;
  logic signed [W-1:0] y_r;
  logic signed [W-1:0] z_r;

  logic [31:0]         ang_q;
  logic                flip;
  logic [31:0]         zsrc;
  logic signed [W-1:0] dx;
  logic signed [W-1:0] dy;
  logic signed [W-1:0] atan_v;
  logic                last;

  // quadrant fold: angles in [90,270) deg are turned by half a circle
  always_comb begin
    ang_q  = angle + 32'h4000_0000;
    flip   = ang_q[31];
    zsrc   = flip ? (angle ^ 32'h8000_0000) : angle;
    dx     = y_r >>> idx_r;
    dy     = x_r >>> idx_r;
    atan_v = W'(ddo_pkg::atan_entry(idx_r));
    last   = (idx_r == 5'(STEPS - 1));
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      done_r <= run_r && last;
      if (start) begin
        run_r <= 1'b1;
        idx_r <= '0;
      end else if (run_r) begin
        if (last) begin
          run_r <= 1'b0;
        end else begin
          idx_r <= idx_r + 5'd1;
        end
      end
    end
  end

  // micro-rotations
  always_ff @(posedge clk) begin
    if (start) begin
      flip_r <= flip;
      x_r    <= W'(ddo_pkg::CORDIC_INIT);
      y_r    <= '0;
      z_r    <= {{(W-32){zsrc[31]}}, zsrc};
    end else if (run_r) begin
      if (!z_r[W-1]) begin
        x_r <= x_r - dx;
        y_r <= y_r + dy;
        z_r <= z_r - atan_v;
      end else begin
        x_r <= x_r + dx;
        y_r <= y_r - dy;
        z_r <= z_r + atan_v;
      end
    end
  end

  assign done        = done_r;
  assign trig.cosine = flip_r ? -x_r : x_r;
  assign trig.sine   = flip_r ? -y_r : y_r;

endmodule
